[rtl/core/mm64_pkg.sv]
// Shared constants and helper functions for the MurmurHash64A stream hasher.
`default_nettype none

package mm64_pkg;

    localparam logic [63:0] MIX_MUL     = 64'hc6a4a7935bd1e995;
    localparam logic [31:0] MIX_MUL_LO  = MIX_MUL[31:0];
    localparam logic [31:0] MIX_MUL_HI  = MIX_MUL[63:32];
    localparam int unsigned MIX_SHIFT   = 47;
    localparam logic [63:0] SEED_RESET  = 64'h0000_0000_dead_beef;
    localparam logic [3:0]  BLOCK_BYTES = 4'd8;
    localparam logic [1:0]  MUL_LAST_STEP = 2'd2;

    // h ^ (h >> 47)
    function automatic logic [63:0] xorshift(input logic [63:0] h);
        xorshift = h ^ (h >> MIX_SHIFT);
    endfunction

    // Limit a byte count to one full word.
    function automatic logic [3:0] clamp_bytes(input logic [3:0] n);
        clamp_bytes = (n > BLOCK_BYTES) ? BLOCK_BYTES : n;
    endfunction

    // Keep the low n bytes of w, zero the rest.
    function automatic logic [63:0] low_bytes(input logic [63:0] w, input logic [3:0] n);
        logic [63:0] r;
        r = '0;
        for (int i = 0; i < 8; i++) begin
            if (4'(i) < n) begin
                r[8*i +: 8] = w[8*i +: 8];
            end
        end
        low_bytes = r;
    endfunction

endpackage

`default_nettype wire

[rtl/core/mm64_mul.sv]
// Iterative 64-bit multiply by the mix constant, modulo 2^64, one 32x32 product per cycle.
`default_nettype none

module mm64_mul (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [63:0] operand,
    output logic             busy,
    output logic             done,
    output logic [63:0]      result
);

    logic [63:0] a_reg;
    logic [63:0] res_reg, res_next;
    logic [1:0]  step_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [31:0] op_a, op_b;
    logic [63:0] prod;

    // low word of a*M = al*ml + ((al*mh + ah*ml) << 32)
    always_comb begin
        case (step_reg)
            2'd0: begin
                op_a = a_reg[31:0];
                op_b = mm64_pkg::MIX_MUL_LO;
            end
            2'd1: begin
                op_a = a_reg[31:0];
                op_b = mm64_pkg::MIX_MUL_HI;
            end
            default: begin
                op_a = a_reg[63:32];
                op_b = mm64_pkg::MIX_MUL_LO;
            end
        endcase
    end

    assign prod = 64'(op_a) * 64'(op_b);

    always_comb begin
        if (step_reg == 2'd0) begin
            res_next = prod;
        end else begin
            res_next = {res_reg[63:32] + prod[31:0], res_reg[31:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg <= operand;
        end
        if (busy_reg) begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 2'd0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= 2'd0;
            end else if (busy_reg) begin
                if (step_reg == mm64_pkg::MUL_LAST_STEP) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    step_reg <= 2'd0;
                end else begin
                    step_reg <= step_reg + 2'd1;
                end
            end
        end
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = res_reg;

endmodule

`default_nettype wire

[rtl/core/murmur64a_stream_hasher_core.sv]
// Top level: word sequencer, seed register and result register around the shared multiplier.
//
//  channel  | handshake          | payload
//  ---------+--------------------+----------------------------------------------------
//  input    | s_valid / s_ready  | s_data_word, s_valid_bytes, s_first_word,
//           |                    | s_last_word, s_message_length
//  result   | m_valid / m_ready  | m_hash_value
//  config   | cfg_wr_en          | cfg_wr_data (seed)
//
// Each multiply by the mix constant runs on the one shared 32x32 multiplier.
// Multiplies per word: 1 for first_word, 3 for a full block, 1 for a 1..7 byte tail,
// 1 for last_word; after the last one the result register is loaded in S_EMIT.
// s_ready is high only in the idle state; a waiting result does not block the input.
// The result register holds until taken; the sequencer waits there only for a new result.
// Synchronous reset clears the sequencer, running hash and valid flags; seed -> 0xdeadbeef.
`default_nettype none

module murmur64a_stream_hasher_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [63:0] cfg_wr_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [63:0] s_data_word,
    input  wire logic [3:0]  s_valid_bytes,
    input  wire logic        s_first_word,
    input  wire logic        s_last_word,
    input  wire logic [31:0] s_message_length,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [63:0]      m_hash_value
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_LOAD = 8'b0000_0010,
        S_LEN  = 8'b0000_0100,
        S_KA   = 8'b0000_1000,
        S_KB   = 8'b0001_0000,
        S_HM   = 8'b0010_0000,
        S_FIN  = 8'b0100_0000,
        S_EMIT = 8'b1000_0000
    } state_t;

    state_t      state_reg, state_next;
    logic [63:0] seed_reg;
    logic [63:0] h_reg, h_next;
    logic [63:0] word_reg;
    logic [3:0]  nb_reg;
    logic        first_reg;
    logic        last_reg;
    logic [31:0] len_reg;
    logic        m_valid_reg;
    logic [63:0] m_hash_reg;
    logic        out_load;

    logic        mul_start;
    logic [63:0] mul_operand;
    logic        mul_busy;
    logic        mul_done;
    logic [63:0] mul_result;

    logic [63:0] adv_h;
    logic        adv_mix;
    logic        adv_go;
    logic [63:0] adv_operand;
    state_t      adv_state;

    logic        s_xfer;

    assign s_ready = (state_reg == S_IDLE);
    assign s_xfer  = s_valid && s_ready;

    mm64_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .operand (mul_operand),
        .busy    (mul_busy),
        .done    (mul_done),
        .result  (mul_result)
    );

    // Running hash into the next step: mix the word once, then finalize if last.
    always_comb begin
        unique case (state_reg)
            S_LOAD: begin
                adv_h   = h_reg;
                adv_mix = 1'b1;
            end
            S_LEN: begin
                adv_h   = seed_reg ^ mul_result;
                adv_mix = 1'b1;
            end
            default: begin
                adv_h   = mul_result;
                adv_mix = 1'b0;
            end
        endcase
    end

    always_comb begin
        adv_go      = 1'b1;
        adv_operand = adv_h;
        adv_state   = S_IDLE;
        if (adv_mix && nb_reg == mm64_pkg::BLOCK_BYTES) begin
            adv_operand = word_reg;
            adv_state   = S_KA;
        end else if (adv_mix && nb_reg != 4'd0) begin
            adv_operand = adv_h ^ mm64_pkg::low_bytes(word_reg, nb_reg);
            adv_state   = S_HM;
        end else if (last_reg) begin
            adv_operand = mm64_pkg::xorshift(adv_h);
            adv_state   = S_FIN;
        end else begin
            adv_go = 1'b0;
        end
    end

    always_comb begin
        state_next  = state_reg;
        h_next      = h_reg;
        mul_start   = 1'b0;
        mul_operand = '0;
        out_load    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_xfer) begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD: begin
                if (first_reg) begin
                    mul_start   = 1'b1;
                    mul_operand = {32'd0, len_reg};
                    state_next  = S_LEN;
                end else begin
                    h_next      = adv_h;
                    mul_start   = adv_go;
                    mul_operand = adv_operand;
                    state_next  = adv_state;
                end
            end
            S_LEN, S_HM: begin
                if (mul_done) begin
                    h_next      = adv_h;
                    mul_start   = adv_go;
                    mul_operand = adv_operand;
                    state_next  = adv_state;
                end
            end
            S_KA: begin
                if (mul_done) begin
                    mul_start   = 1'b1;
                    mul_operand = mm64_pkg::xorshift(mul_result);
                    state_next  = S_KB;
                end
            end
            S_KB: begin
                if (mul_done) begin
                    mul_start   = 1'b1;
                    mul_operand = h_reg ^ mul_result;
                    state_next  = S_HM;
                end
            end
            S_FIN: begin
                if (mul_done) begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                // wait for a free result register, then clear the running hash
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    h_next     = '0;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            h_reg       <= '0;
            seed_reg    <= mm64_pkg::SEED_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            h_reg     <= h_next;
            if (cfg_wr_en) begin
                seed_reg <= cfg_wr_data;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            word_reg  <= s_data_word;
            nb_reg    <= mm64_pkg::clamp_bytes(s_valid_bytes);
            first_reg <= s_first_word;
            last_reg  <= s_last_word;
            len_reg   <= s_message_length;
        end
        if (out_load) begin
            m_hash_reg <= mm64_pkg::xorshift(mul_result);
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_hash_value = m_hash_reg;

`ifndef ASSERT_OFF
    a_start_idle_unit: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_start |-> !mul_busy)
        else $error("multiplier restarted while busy");

    a_done_in_mul_state: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> (state_reg == S_LEN || state_reg == S_KA || state_reg == S_KB ||
                      state_reg == S_HM || state_reg == S_FIN))
        else $error("multiplier done outside a multiply state");

    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_busy |-> !s_ready)
        else $error("input ready while multiplier busy");

    a_xfer_to_load: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> state_reg == S_LOAD)
        else $error("accepted transfer did not start the sequence");

    a_emit_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_valid_reg && h_reg == 64'd0 && state_reg == S_IDLE)
        else $error("result load did not present result and clear hash");
`endif

endmodule

`default_nettype wire
